>>> rtl/ezm_pkg.sv
// Shared types and constants of the ZYX Euler transform pipeline.
// No dependencies; every other file imports it.
package ezm_pkg;

  // stage counts of each unit
  localparam int LAT_ANG   = 4;
  localparam int LAT_SIN   = 7;
  localparam int LAT_SEL   = 1;
  localparam int LAT_ROT   = 4;
  localparam int LAT_TO_ROT = LAT_ANG + LAT_SIN + LAT_SEL;
  localparam int LAT_TOTAL = LAT_TO_ROT + LAT_ROT;

  // angle units: 1/64 degree
  localparam logic [16:0] ANG_FULL  = 17'd23040;
  localparam logic [16:0] ANG_BIAS  = 17'd46080;
  localparam logic [16:0] ANG_3FULL = 17'd69120;
  localparam logic [14:0] ANG_Q1    = 15'd5760;
  localparam logic [14:0] ANG_Q2    = 15'd11520;
  localparam logic [14:0] ANG_Q3    = 15'd17280;
  localparam logic [12:0] ANG_QUAD  = 13'd5760;

  // r * 2^30 / 5760 = r * 186413 + (23 r + 22) / 45
  localparam logic [30:0] X_MUL    = 31'd186413;
  localparam logic [17:0] X_REM    = 18'd23;
  localparam logic [17:0] X_RND    = 18'd22;
  localparam logic [36:0] INV45    = 37'd372828;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  localparam logic signed [31:0] SIN_COEF [5] = '{
    32'sd1686629713, -32'sd693598668, 32'sd85569306, -32'sd5026995, 32'sd172272
  };
  localparam logic [14:0] ONE_Q14 = 15'd16384;

  typedef logic [30:0] xq_t;
  typedef logic [14:0] qs_t;
  typedef logic signed [15:0] trig_val_t;
  typedef logic signed [23:0] scl_t;

  typedef struct packed {
    trig_val_t sx;
    trig_val_t cx;
    trig_val_t sy;
    trig_val_t cy;
    trig_val_t sz;
    trig_val_t cz;
  } trig_t;

  typedef struct packed {
    scl_t x;
    scl_t y;
    scl_t z;
  } scale_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } pos_t;

endpackage

>>> rtl/euler_zyx_trs_matrix.sv
// ZYX Euler scale/rotate/translate matrix, top level.
// Start a beat by raising start with the position, angles and scales on the
// in_ ports; busy never rises, so a beat is taken on every cycle start is high.
// For each beat taken, out_valid is high for one cycle with the 3x4 transform
// on the out_ ports; out_m03/13/23 carry the position.
// Throughput is one beat per clock. The chain runs through angle reduction,
// the quarter-wave sine polynomial (one product per stage), quadrant sign
// selection, and rotation product and column scaling.
// There is no state beyond the pipeline. A synchronous reset (rst_n low)
// drops every beat in flight; payload registers are not cleared.
// The receiver cannot stall: each result is shown for one cycle only, and a
// new one can follow on every cycle.
// Depends on ezm_pkg, ezm_angle, ezm_qsin and ezm_rot.
module euler_zyx_trs_matrix (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [15:0] in_angle_x,
  input  logic signed [15:0] in_angle_y,
  input  logic signed [15:0] in_angle_z,
  input  logic signed [23:0] in_scale_x,
  input  logic signed [23:0] in_scale_y,
  input  logic signed [23:0] in_scale_z,
  output logic               out_valid,
  output logic signed [31:0] out_m00,
  output logic signed [31:0] out_m01,
  output logic signed [31:0] out_m02,
  output logic signed [31:0] out_m03,
  output logic signed [31:0] out_m10,
  output logic signed [31:0] out_m11,
  output logic signed [31:0] out_m12,
  output logic signed [31:0] out_m13,
  output logic signed [31:0] out_m20,
  output logic signed [31:0] out_m21,
  output logic signed [31:0] out_m22,
  output logic signed [31:0] out_m23
);
  import ezm_pkg::*;

  logic [LAT_TOTAL-1:0] vld_r;
  pos_t                 pos_r [LAT_TOTAL];
  scale_t               sc_r [LAT_TO_ROT];
  logic signed [15:0]   ang [3];
  xq_t                  xs [3];
  xq_t                  xc [3];
  logic [1:0]           quad [3];
  logic [1:0]           quad_r [3][LAT_SIN];
  qs_t                  sp [3];
  qs_t                  sq [3];
  trig_val_t            sn_r [3];
  trig_val_t            cs_r [3];
  trig_t                trig;
  logic [31:0]          m [9];

  // always ready
  assign busy = 1'b0;

  // advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT_TOTAL-2:0], start};
    end
  end

  // carry position and scale alongside
  always_ff @(posedge clk) begin
    pos_r[0] <= '{x: in_pos_x, y: in_pos_y, z: in_pos_z};
    sc_r[0]  <= '{x: in_scale_x, y: in_scale_y, z: in_scale_z};
    for (int k = 1; k < LAT_TOTAL; k++) begin
      pos_r[k] <= pos_r[k-1];
    end
    for (int k = 1; k < LAT_TO_ROT; k++) begin
      sc_r[k] <= sc_r[k-1];
    end
  end

  assign ang[0] = in_angle_x;
  assign ang[1] = in_angle_y;
  assign ang[2] = in_angle_z;

  // per-axis sine and cosine
  for (genvar a = 0; a < 3; a++) begin : g_axis
    ezm_angle u_angle (
      .clk   (clk),
      .angle (ang[a]),
      .x_s   (xs[a]),
      .x_c   (xc[a]),
      .quad  (quad[a])
    );

    ezm_qsin u_sin (
      .clk (clk),
      .x   (xs[a]),
      .s   (sp[a])
    );

    ezm_qsin u_cos (
      .clk (clk),
      .x   (xc[a]),
      .s   (sq[a])
    );

    always_ff @(posedge clk) begin
      quad_r[a][0] <= quad[a];
      for (int k = 1; k < LAT_SIN; k++) begin
        quad_r[a][k] <= quad_r[a][k-1];
      end
    end

    // apply quadrant signs
    always_ff @(posedge clk) begin
      case (quad_r[a][LAT_SIN-1])
        QUAD_0: begin
          sn_r[a] <= 16'(sp[a]);
          cs_r[a] <= 16'(sq[a]);
        end
        QUAD_1: begin
          sn_r[a] <= 16'(sq[a]);
          cs_r[a] <= -16'(sp[a]);
        end
        QUAD_2: begin
          sn_r[a] <= -16'(sp[a]);
          cs_r[a] <= -16'(sq[a]);
        end
        default: begin
          sn_r[a] <= -16'(sq[a]);
          cs_r[a] <= 16'(sp[a]);
        end
      endcase
    end
  end

  assign trig = '{sx: sn_r[0], cx: cs_r[0], sy: sn_r[1], cy: cs_r[1],
                  sz: sn_r[2], cz: cs_r[2]};

  ezm_rot u_rot (
    .clk   (clk),
    .trig  (trig),
    .scale (sc_r[LAT_TO_ROT-1]),
    .m     (m)
  );

  assign out_valid = vld_r[LAT_TOTAL-1];
  assign out_m00 = m[0];
  assign out_m01 = m[1];
  assign out_m02 = m[2];
  assign out_m03 = pos_r[LAT_TOTAL-1].x;
  assign out_m10 = m[3];
  assign out_m11 = m[4];
  assign out_m12 = m[5];
  assign out_m13 = pos_r[LAT_TOTAL-1].y;
  assign out_m20 = m[6];
  assign out_m21 = m[7];
  assign out_m22 = m[8];
  assign out_m23 = pos_r[LAT_TOTAL-1].z;

`ifndef SYNTHESIS
  a_rst_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe after reset");
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT_TOTAL))
    else $error("result without a matching beat");
  a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##LAT_TOTAL out_valid)
    else $error("beat lost in pipeline");
`endif

endmodule

>>> rtl/ezm_angle.sv
// Angle reduction: wraps a 1/64-degree angle, splits quadrant and remainder,
// and scales both remainders to Q1.30 phase. Depends on ezm_pkg.
module ezm_angle (
  input  logic               clk,
  input  logic signed [15:0] angle,
  output ezm_pkg::xq_t       x_s,
  output ezm_pkg::xq_t       x_c,
  output logic [1:0]         quad
);
  import ezm_pkg::*;

  logic [16:0] wrap;
  logic [14:0] a_nxt, a_r;
  logic [1:0]  q_nxt, q2_r, q3_r, q4_r;
  logic [14:0] rr_nxt;
  logic [12:0] r_r [2];
  logic [30:0] m1_r [2];
  logic [36:0] m2_r [2];
  xq_t         x_r [2];

  // fold into 0..360 degrees
  assign wrap = {angle[15], angle} + ANG_BIAS;
  always_comb begin
    if (wrap >= ANG_3FULL) begin
      a_nxt = 15'(wrap - ANG_3FULL);
    end else if (wrap >= ANG_BIAS) begin
      a_nxt = 15'(wrap - ANG_BIAS);
    end else if (wrap >= ANG_FULL) begin
      a_nxt = 15'(wrap - ANG_FULL);
    end else begin
      // angles below -360 degrees wrap twice
      a_nxt = wrap[14:0];
    end
  end

  // split quadrant and remainder
  always_comb begin
    if (a_r >= ANG_Q3) begin
      q_nxt  = QUAD_3;
      rr_nxt = a_r - ANG_Q3;
    end else if (a_r >= ANG_Q2) begin
      q_nxt  = QUAD_2;
      rr_nxt = a_r - ANG_Q2;
    end else if (a_r >= ANG_Q1) begin
      q_nxt  = QUAD_1;
      rr_nxt = a_r - ANG_Q1;
    end else begin
      q_nxt  = QUAD_0;
      rr_nxt = a_r;
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    q2_r   <= q_nxt;
    r_r[0] <= rr_nxt[12:0];
    r_r[1] <= ANG_QUAD - rr_nxt[12:0];
    q3_r   <= q2_r;
    q4_r   <= q3_r;
  end

  // scale both remainders to phase, sine and complement lanes
  for (genvar k = 0; k < 2; k++) begin : g_lane
    always_ff @(posedge clk) begin
      m1_r[k] <= 31'(r_r[k]) * X_MUL;
      m2_r[k] <= 37'(18'(r_r[k]) * X_REM + X_RND) * INV45;
      x_r[k]  <= m1_r[k] + 31'(m2_r[k][36:24]);
    end
  end

  assign x_s  = x_r[0];
  assign x_c  = x_r[1];
  assign quad = q4_r;

endmodule

>>> rtl/ezm_qsin.sv
// Quarter-wave sine: Horner polynomial on a Q1.30 phase, one product a stage,
// rounded and clamped to Q1.14. Depends on ezm_pkg.
module ezm_qsin (
  input  logic         clk,
  input  ezm_pkg::xq_t x,
  output ezm_pkg::qs_t s
);
  import ezm_pkg::*;

  logic [61:0]        sq_r;
  xq_t                x_r [5];
  logic signed [31:0] x2_r [3];
  logic signed [63:0] prod_r [5];
  logic signed [31:0] p_nxt [1:4];
  logic signed [63:0] t_nxt;
  qs_t                s_r;

  // square the phase
  always_ff @(posedge clk) begin
    sq_r   <= 62'(x) * 62'(x);
    x_r[0] <= x;
    for (int k = 1; k < 5; k++) begin
      x_r[k] <= x_r[k-1];
    end
  end

  // leading coefficient times x^2
  always_ff @(posedge clk) begin
    x2_r[0]   <= 32'({1'b0, sq_r[60:30]});
    x2_r[1]   <= x2_r[0];
    x2_r[2]   <= x2_r[1];
    prod_r[0] <= 64'(SIN_COEF[4]) * 64'({1'b0, sq_r[60:30]});
  end

  // Horner steps on x^2
  for (genvar k = 1; k < 4; k++) begin : g_horner
    assign p_nxt[k] = SIN_COEF[4-k] + 32'(prod_r[k-1] >>> 30);
    always_ff @(posedge clk) begin
      prod_r[k] <= 64'(p_nxt[k]) * 64'(x2_r[k-1]);
    end
  end

  // last step multiplies by x
  assign p_nxt[4] = SIN_COEF[0] + 32'(prod_r[3] >>> 30);
  always_ff @(posedge clk) begin
    prod_r[4] <= 64'(p_nxt[4]) * 64'({1'b0, x_r[4]});
  end

  // round to Q1.14 and clamp
  assign t_nxt = ((prod_r[4] >>> 30) + 64'sd32768) >>> 16;
  always_ff @(posedge clk) begin
    if (t_nxt < 0) begin
      s_r <= '0;
    end else if (t_nxt > 64'(ONE_Q14)) begin
      s_r <= ONE_Q14;
    end else begin
      s_r <= t_nxt[14:0];
    end
  end

  assign s = s_r;

endmodule

>>> rtl/ezm_rot.sv
// Rotation entries of Rz*Ry*Rx in Q.42, rounded to Q.28 and scaled per column
// to Q16.16. Depends on ezm_pkg.
module ezm_rot (
  input  logic            clk,
  input  ezm_pkg::trig_t  trig,
  input  ezm_pkg::scale_t scale,
  output logic [31:0]     m [9]
);
  import ezm_pkg::*;

  logic signed [31:0] czsy_r, czcy_r, szsy_r, szcy_r, szcx_r;
  logic signed [31:0] szsx_r, czcx_r, czsx_r, cysx_r, cycx_r;
  trig_val_t          sx_r, cx_r, sy_r;
  scale_t             sc1_r, sc2_r;
  logic signed [45:0] e_nxt [9];
  logic signed [45:0] e_r [9];
  scl_t               col_sc [3];
  logic signed [63:0] prod_r [9];
  logic [31:0]        m_r [9];

  // two-factor products
  always_ff @(posedge clk) begin
    czsy_r <= 32'(trig.cz * trig.sy);
    czcy_r <= 32'(trig.cz * trig.cy);
    szsy_r <= 32'(trig.sz * trig.sy);
    szcy_r <= 32'(trig.sz * trig.cy);
    szcx_r <= 32'(trig.sz * trig.cx);
    szsx_r <= 32'(trig.sz * trig.sx);
    czcx_r <= 32'(trig.cz * trig.cx);
    czsx_r <= 32'(trig.cz * trig.sx);
    cysx_r <= 32'(trig.cy * trig.sx);
    cycx_r <= 32'(trig.cy * trig.cx);
    sx_r   <= trig.sx;
    cx_r   <= trig.cx;
    sy_r   <= trig.sy;
    sc1_r  <= scale;
  end

  // exact entries in Q.42
  always_comb begin
    e_nxt[0] = 46'(czcy_r) <<< 14;
    e_nxt[1] = 46'(czsy_r) * 46'(sx_r) - (46'(szcx_r) <<< 14);
    e_nxt[2] = 46'(czsy_r) * 46'(cx_r) + (46'(szsx_r) <<< 14);
    e_nxt[3] = 46'(szcy_r) <<< 14;
    e_nxt[4] = 46'(szsy_r) * 46'(sx_r) + (46'(czcx_r) <<< 14);
    e_nxt[5] = 46'(szsy_r) * 46'(cx_r) - (46'(czsx_r) <<< 14);
    e_nxt[6] = -(46'(sy_r) <<< 28);
    e_nxt[7] = 46'(cysx_r) <<< 14;
    e_nxt[8] = 46'(cycx_r) <<< 14;
  end

  always_ff @(posedge clk) begin
    e_r   <= e_nxt;
    sc2_r <= sc1_r;
  end

  assign col_sc[0] = sc2_r.x;
  assign col_sc[1] = sc2_r.y;
  assign col_sc[2] = sc2_r.z;

  // round to Q.28, scale, round to Q16.16
  for (genvar i = 0; i < 9; i++) begin : g_ent
    always_ff @(posedge clk) begin
      prod_r[i] <= 64'(32'((e_r[i] + 46'sd8192) >>> 14)) * 64'(col_sc[i % 3]);
      m_r[i]    <= 32'((prod_r[i] + 64'sd134217728) >>> 28);
    end
  end

  assign m = m_r;

endmodule
